[sv/shabs_pkg.sv]
// Shared types, constants and the round constant table of the SHA-256 byte stream hasher.
package shabs_pkg;

   localparam int unsigned BlockBits = 512;
   localparam int unsigned DigestBits = 256;
   localparam int unsigned LenStart = 56;
   localparam logic [7:0] PadByte = 8'h80;

   typedef struct packed {
      logic start;
      logic restart;
   } core_ctl_type;

   typedef struct packed {
      logic done;
   } core_stat_type;

   function automatic logic [31:0] iv_word(input logic [2:0] idx);
      logic [31:0] r;
      unique case (idx)
         3'd0: r = 32'h6a09e667;
         3'd1: r = 32'hbb67ae85;
         3'd2: r = 32'h3c6ef372;
         3'd3: r = 32'ha54ff53a;
         3'd4: r = 32'h510e527f;
         3'd5: r = 32'h9b05688c;
         3'd6: r = 32'h1f83d9ab;
         default: r = 32'h5be0cd19;
      endcase
      return r;
   endfunction

   function automatic logic [31:0] round_k(input logic [5:0] idx);
      logic [31:0] r;
      unique case (idx)
         6'd0: r = 32'h428a2f98;  6'd1: r = 32'h71374491;
         6'd2: r = 32'hb5c0fbcf;  6'd3: r = 32'he9b5dba5;
         6'd4: r = 32'h3956c25b;  6'd5: r = 32'h59f111f1;
         6'd6: r = 32'h923f82a4;  6'd7: r = 32'hab1c5ed5;
         6'd8: r = 32'hd807aa98;  6'd9: r = 32'h12835b01;
         6'd10: r = 32'h243185be; 6'd11: r = 32'h550c7dc3;
         6'd12: r = 32'h72be5d74; 6'd13: r = 32'h80deb1fe;
         6'd14: r = 32'h9bdc06a7; 6'd15: r = 32'hc19bf174;
         6'd16: r = 32'he49b69c1; 6'd17: r = 32'hefbe4786;
         6'd18: r = 32'h0fc19dc6; 6'd19: r = 32'h240ca1cc;
         6'd20: r = 32'h2de92c6f; 6'd21: r = 32'h4a7484aa;
         6'd22: r = 32'h5cb0a9dc; 6'd23: r = 32'h76f988da;
         6'd24: r = 32'h983e5152; 6'd25: r = 32'ha831c66d;
         6'd26: r = 32'hb00327c8; 6'd27: r = 32'hbf597fc7;
         6'd28: r = 32'hc6e00bf3; 6'd29: r = 32'hd5a79147;
         6'd30: r = 32'h06ca6351; 6'd31: r = 32'h14292967;
         6'd32: r = 32'h27b70a85; 6'd33: r = 32'h2e1b2138;
         6'd34: r = 32'h4d2c6dfc; 6'd35: r = 32'h53380d13;
         6'd36: r = 32'h650a7354; 6'd37: r = 32'h766a0abb;
         6'd38: r = 32'h81c2c92e; 6'd39: r = 32'h92722c85;
         6'd40: r = 32'ha2bfe8a1; 6'd41: r = 32'ha81a664b;
         6'd42: r = 32'hc24b8b70; 6'd43: r = 32'hc76c51a3;
         6'd44: r = 32'hd192e819; 6'd45: r = 32'hd6990624;
         6'd46: r = 32'hf40e3585; 6'd47: r = 32'h106aa070;
         6'd48: r = 32'h19a4c116; 6'd49: r = 32'h1e376c08;
         6'd50: r = 32'h2748774c; 6'd51: r = 32'h34b0bcb5;
         6'd52: r = 32'h391c0cb3; 6'd53: r = 32'h4ed8aa4a;
         6'd54: r = 32'h5b9cca4f; 6'd55: r = 32'h682e6ff3;
         6'd56: r = 32'h748f82ee; 6'd57: r = 32'h78a5636f;
         6'd58: r = 32'h84c87814; 6'd59: r = 32'h8cc70208;
         6'd60: r = 32'h90befffa; 6'd61: r = 32'ha4506ceb;
         6'd62: r = 32'hbef9a3f7; default: r = 32'hc67178f2;
      endcase
      return r;
   endfunction

endpackage

[sv/shabs_round_core.sv]
// SHA-256 compression core: one round per cycle with a rolling schedule window.
module shabs_round_core
   import shabs_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  core_ctl_type          ctl,
   input  logic [BlockBits-1:0]  block,
   output core_stat_type         stat,
   output logic [DigestBits-1:0] digest
);

   typedef enum logic [2:0] {
      CS_IDLE = 3'b001,
      CS_RUN  = 3'b010,
      CS_ADD  = 3'b100
   } core_state_type;

   core_state_type st_ff, st_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [31:0] h_ff [8];
   logic [31:0] h_in [8];
   logic [31:0] v_ff [8];
   logic [31:0] v_in [8];
   logic [31:0] w_ff [16];
   logic [31:0] w_in [16];

   logic [31:0] bs1, bs0, ch, maj, t1, t2, ss0, ss1, w_next;

   function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
      return (x >> n) | (x << (32 - n));
   endfunction

   always_comb begin
      bs1 = rotr(v_ff[4], 6) ^ rotr(v_ff[4], 11) ^ rotr(v_ff[4], 25);
      ch  = (v_ff[4] & v_ff[5]) ^ (~v_ff[4] & v_ff[6]);
      t1  = v_ff[7] + bs1 + ch + round_k(cnt_ff) + w_ff[0];
      bs0 = rotr(v_ff[0], 2) ^ rotr(v_ff[0], 13) ^ rotr(v_ff[0], 22);
      maj = (v_ff[0] & v_ff[1]) ^ (v_ff[0] & v_ff[2]) ^ (v_ff[1] & v_ff[2]);
      t2  = bs0 + maj;
      ss1 = rotr(w_ff[14], 17) ^ rotr(w_ff[14], 19) ^ (w_ff[14] >> 10);
      ss0 = rotr(w_ff[1], 7) ^ rotr(w_ff[1], 18) ^ (w_ff[1] >> 3);
      w_next = ss1 + w_ff[9] + ss0 + w_ff[0];
   end

   always_comb begin
      st_in  = st_ff;
      cnt_in = cnt_ff;
      h_in   = h_ff;
      v_in   = v_ff;
      w_in   = w_ff;
      unique case (st_ff)
         CS_IDLE: begin
            if (ctl.start) begin
               for (int k = 0; k < 16; k++) begin
                  w_in[k] = block[BlockBits-1-32*k -: 32];
               end
               v_in   = h_ff;
               cnt_in = '0;
               st_in  = CS_RUN;
            end
         end
         CS_RUN: begin
            // advance the window and the working variables
            for (int k = 0; k < 15; k++) begin
               w_in[k] = w_ff[k+1];
            end
            w_in[15] = w_next;
            v_in[7] = v_ff[6];
            v_in[6] = v_ff[5];
            v_in[5] = v_ff[4];
            v_in[4] = v_ff[3] + t1;
            v_in[3] = v_ff[2];
            v_in[2] = v_ff[1];
            v_in[1] = v_ff[0];
            v_in[0] = t1 + t2;
            cnt_in  = cnt_ff + 6'd1;
            if (cnt_ff == 6'd63) begin
               st_in = CS_ADD;
            end
         end
         CS_ADD: begin
            for (int k = 0; k < 8; k++) begin
               h_in[k] = h_ff[k] + v_ff[k];
            end
            st_in = CS_IDLE;
         end
         default: st_in = CS_IDLE;
      endcase
      if (ctl.restart) begin
         for (int k = 0; k < 8; k++) begin
            h_in[k] = iv_word(3'(k));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff  <= CS_IDLE;
         cnt_ff <= '0;
         for (int k = 0; k < 8; k++) begin
            h_ff[k] <= iv_word(3'(k));
         end
      end else begin
         st_ff  <= st_in;
         cnt_ff <= cnt_in;
         h_ff   <= h_in;
      end
   end

   always_ff @(posedge clock) begin
      v_ff <= v_in;
      w_ff <= w_in;
   end

   assign stat.done = (st_ff == CS_ADD);

   always_comb begin
      for (int k = 0; k < 8; k++) begin
         digest[DigestBits-1-32*k -: 32] = h_ff[k];
      end
   end

endmodule

[sv/sha256_byte_stream_hasher_top.sv]
// Top level of the SHA-256 byte stream hasher: byte buffer, padding sequencer, digest output.
//
// Usage: feed a message one byte per input word on the req_ channel
// (req_msg_byte with req_byte_valid, req_end_of_message closes the message
// after that word's byte; an end word with no byte is allowed).
// The 64th byte of a block is loaded into the shared round core on the
// accepting edge: 64 rounds at one per cycle plus the final add, during
// which req_ready is low.
// At the end of a message the sequencer shifts in 0x80, zero bytes and the
// eight length bytes, one byte per cycle outside the core runs, running
// the core once or twice (twice when fewer than eight bytes remain after
// 0x80) before the first digest word is shown.
// The digest then appears as four 64-bit words on the rsp_ channel, most
// significant first, with rsp_word_index 0..3 and rsp_last_word on the last.
// The digest is held in the core's hash registers, so a stalled receiver
// simply holds rsp_valid and the word; nothing is lost or repeated.
// After the last word is taken the hash, byte count and bit count return to
// their initial values and the next message may begin.
// Reset (synchronous, active high) gives the same initial state at once.
module sha256_byte_stream_hasher_top
   import shabs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_msg_byte,
   input  logic        req_byte_valid,
   input  logic        req_end_of_message,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [63:0] rsp_digest_word,
   output logic [1:0]  rsp_word_index,
   output logic        rsp_last_word
);

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_COMP = 4'b0010,
      ST_PAD  = 4'b0100,
      ST_OUT  = 4'b1000
   } state_type;

   typedef enum logic [1:0] {
      RET_IDLE = 2'd0,
      RET_PAD  = 2'd1,
      RET_OUT  = 2'd2
   } ret_type;

   state_type st_ff, st_in;
   ret_type   ret_ff, ret_in;
   logic [5:0]  fill_ff, fill_in;
   logic [63:0] bits_ff, bits_in;
   logic        pad80_ff, pad80_in;
   logic        lenblk_ff, lenblk_in;
   logic [1:0]  idx_ff, idx_in;
   logic [BlockBits-1:0] buf_ff, buf_in;

   core_ctl_type  ctl;
   core_stat_type stat;
   logic [DigestBits-1:0] digest;
   logic [7:0]  pad_byte, len_byte;
   logic [63:0] len_shift;
   logic        in_acc, out_acc;

   // load the block including the byte shifted in on the starting edge
   shabs_round_core u_core (
      .clock  (clock),
      .reset  (reset),
      .ctl    (ctl),
      .block  (buf_in),
      .stat   (stat),
      .digest (digest)
   );

   assign req_ready = (st_ff == ST_IDLE);
   assign rsp_valid = (st_ff == ST_OUT);
   assign in_acc    = req_valid && req_ready;
   assign out_acc   = rsp_valid && rsp_ready;

   // length bytes go out most significant first at fill positions 56..63
   assign len_shift = bits_ff >> {(3'd7 - fill_ff[2:0]), 3'b000};
   assign len_byte  = len_shift[7:0];

   always_comb begin
      if (pad80_ff) begin
         pad_byte = PadByte;
      end else if (lenblk_ff && (fill_ff >= 6'(LenStart))) begin
         pad_byte = len_byte;
      end else begin
         pad_byte = 8'h00;
      end
   end

   always_comb begin
      st_in       = st_ff;
      ret_in      = ret_ff;
      fill_in     = fill_ff;
      bits_in     = bits_ff;
      pad80_in    = pad80_ff;
      lenblk_in   = lenblk_ff;
      idx_in      = idx_ff;
      buf_in      = buf_ff;
      ctl.start   = 1'b0;
      ctl.restart = 1'b0;
      unique case (st_ff)
         ST_IDLE: begin
            if (in_acc) begin
               pad80_in = req_end_of_message;
               if (req_byte_valid) begin
                  buf_in  = {buf_ff[BlockBits-9:0], req_msg_byte};
                  fill_in = fill_ff + 6'd1;
                  bits_in = bits_ff + 64'd8;
                  if (fill_ff == 6'd63) begin
                     ctl.start = 1'b1;
                     ret_in    = req_end_of_message ? RET_PAD : RET_IDLE;
                     st_in     = ST_COMP;
                  end else if (req_end_of_message) begin
                     st_in = ST_PAD;
                  end
               end else if (req_end_of_message) begin
                  st_in = ST_PAD;
               end
            end
         end
         ST_COMP: begin
            if (stat.done) begin
               unique case (ret_ff)
                  RET_IDLE: st_in = ST_IDLE;
                  RET_PAD: begin
                     st_in     = ST_PAD;
                     lenblk_in = 1'b1;
                  end
                  RET_OUT: begin
                     st_in  = ST_OUT;
                     idx_in = '0;
                  end
                  default: st_in = ST_IDLE;
               endcase
            end
         end
         ST_PAD: begin
            // shift one padding byte a cycle
            buf_in   = {buf_ff[BlockBits-9:0], pad_byte};
            fill_in  = fill_ff + 6'd1;
            pad80_in = 1'b0;
            if (pad80_ff) begin
               lenblk_in = (fill_ff < 6'(LenStart));
            end
            if (fill_ff == 6'd63) begin
               ctl.start = 1'b1;
               ret_in    = (lenblk_ff && !pad80_ff) ? RET_OUT : RET_PAD;
               st_in     = ST_COMP;
            end
         end
         ST_OUT: begin
            if (out_acc) begin
               idx_in = idx_ff + 2'd1;
               if (idx_ff == 2'd3) begin
                  ctl.restart = 1'b1;
                  fill_in     = '0;
                  bits_in     = '0;
                  lenblk_in   = 1'b0;
                  st_in       = ST_IDLE;
               end
            end
         end
         default: st_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff     <= ST_IDLE;
         ret_ff    <= RET_IDLE;
         fill_ff   <= '0;
         bits_ff   <= '0;
         pad80_ff  <= 1'b0;
         lenblk_ff <= 1'b0;
         idx_ff    <= '0;
      end else begin
         st_ff     <= st_in;
         ret_ff    <= ret_in;
         fill_ff   <= fill_in;
         bits_ff   <= bits_in;
         pad80_ff  <= pad80_in;
         lenblk_ff <= lenblk_in;
         idx_ff    <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      buf_ff <= buf_in;
   end

   always_comb begin
      unique case (idx_ff)
         2'd0: rsp_digest_word = digest[255:192];
         2'd1: rsp_digest_word = digest[191:128];
         2'd2: rsp_digest_word = digest[127:64];
         default: rsp_digest_word = digest[63:0];
      endcase
   end

   assign rsp_word_index = idx_ff;
   assign rsp_last_word  = (idx_ff == 2'd3);

   a_out_block_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (fill_ff == 6'd0))
      else $error("digest shown with bytes left in buffer");

   a_start_no_done: assert property (@(posedge clock) disable iff (reset)
      ctl.start |=> !stat.done)
      else $error("core finished right after start");

   a_last_to_idle: assert property (@(posedge clock) disable iff (reset)
      (out_acc && rsp_last_word) |=> (req_ready && (bits_ff == 64'd0)))
      else $error("message state not restarted after digest");

endmodule

[verif/sha256_byte_stream_hasher_top_tb.sv]
// Self-checking testbench of the SHA-256 byte stream hasher, with its own digest predictor.
module sha256_byte_stream_hasher_top_tb;
   import shabs_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned IdleLimit = 20000;
   localparam int unsigned LongHold = 2000;

   typedef struct packed {
      logic [7:0] msg_byte;
      logic       byte_valid;
      logic       end_of_message;
   } byte_word_type;

   typedef struct packed {
      logic [63:0] digest_word;
      logic [1:0]  word_index;
      logic        last_word;
   } digest_beat_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [7:0]  req_msg_byte;
   logic        req_byte_valid;
   logic        req_end_of_message;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [63:0] rsp_digest_word;
   logic [1:0]  rsp_word_index;
   logic        rsp_last_word;

   sha256_byte_stream_hasher_top u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_msg_byte(req_msg_byte), .req_byte_valid(req_byte_valid),
      .req_end_of_message(req_end_of_message),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_digest_word(rsp_digest_word), .rsp_word_index(rsp_word_index),
      .rsp_last_word(rsp_last_word)
   );

   // Predictor state: running hash, block buffer, fill count and bit count.
   logic [31:0] hash_q [8];
   logic [7:0]  blk_q [64];
   logic [6:0]  fill_q;
   logic [63:0] bits_q;

   byte_word_type   pending_words [$];
   digest_beat_type digest_queue [$];
   int unsigned  errors = 0;
   int unsigned  idle_cycles;
   bit           hold_rx;
   bit           pause_tx;

   function automatic logic [31:0] ror(input logic [31:0] x, input int n);
      return (x >> n) | (x << (32 - n));
   endfunction

   task automatic restart_hash();
      for (int i = 0; i < 8; i++) hash_q[i] = iv_word(i[2:0]);
      fill_q = '0;
      bits_q = '0;
   endtask

   task automatic compress();
      logic [31:0] v [8];
      logic [31:0] w [64];
      logic [31:0] t1, t2, s0, s1;
      for (int i = 0; i < 8; i++) v[i] = hash_q[i];
      for (int i = 0; i < 64; i++) begin
         if (i < 16) begin
            w[i] = {blk_q[4*i], blk_q[4*i+1], blk_q[4*i+2], blk_q[4*i+3]};
         end else begin
            s1 = ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10);
            s0 = ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3);
            w[i] = s1 + w[i-7] + s0 + w[i-16];
         end
         t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25)) +
              ((v[4] & v[5]) ^ (~v[4] & v[6])) + round_k(i[5:0]) + w[i];
         t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22)) +
              ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
         v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
         v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
      end
      for (int i = 0; i < 8; i++) hash_q[i] += v[i];
   endtask

   // Advance the predictor by one accepted word; queue four digest beats on an end.
   task automatic predict_digest(input byte_word_type wd);
      int pos;
      digest_beat_type b;
      if (wd.byte_valid) begin
         blk_q[fill_q[5:0]] = wd.msg_byte;
         fill_q++;
         bits_q += 64'd8;
         if (fill_q >= 64) begin
            compress();
            fill_q = '0;
         end
      end
      if (!wd.end_of_message) return;
      pos = fill_q;
      blk_q[pos] = PadByte;
      pos++;
      if (pos > LenStart) begin
         while (pos < 64) blk_q[pos++] = 8'h00;
         compress();
         pos = 0;
      end
      while (pos < LenStart) blk_q[pos++] = 8'h00;
      for (int i = 0; i < 8; i++) blk_q[LenStart + i] = bits_q[63 - 8*i -: 8];
      compress();
      for (int k = 0; k < 4; k++) begin
         b.digest_word = {hash_q[2*k], hash_q[2*k+1]};
         b.word_index = k[1:0];
         b.last_word = (k == 3);
         digest_queue.push_back(b);
      end
      restart_hash();
   endtask

   task automatic add_message(input int len, input bit empty_end);
      byte_word_type wd;
      for (int i = 0; i < len; i++) begin
         wd.msg_byte = 8'($urandom_range(0, 255));
         wd.byte_valid = 1'b1;
         wd.end_of_message = (i == len - 1) && !empty_end;
         // Sprinkle ignored words through the message now and then.
         if ($urandom_range(0, 15) == 0)
            pending_words.push_back('{8'($urandom_range(0, 255)), 1'b0, 1'b0});
         pending_words.push_back(wd);
      end
      if (empty_end || len == 0)
         pending_words.push_back('{8'($urandom_range(0, 255)), 1'b0, 1'b1});
   endtask

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Driver: bursts of words with random gaps; valid held until taken.
   int unsigned gap_cnt;
   int unsigned burst_cnt;
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_msg_byte <= '0;
         req_byte_valid <= 1'b0;
         req_end_of_message <= 1'b0;
         gap_cnt <= 0;
         burst_cnt <= $urandom_range(1, 40);
      end else begin
         if (req_valid && req_ready) predict_digest(
            '{req_msg_byte, req_byte_valid, req_end_of_message});
         if (!req_valid || req_ready) begin
            if (gap_cnt != 0) begin
               gap_cnt <= gap_cnt - 1;
               req_valid <= 1'b0;
            end else if (pending_words.size() != 0 && !pause_tx) begin
               {req_msg_byte, req_byte_valid, req_end_of_message} <=
                  pending_words.pop_front();
               req_valid <= 1'b1;
               if (burst_cnt <= 1) begin
                  burst_cnt <= $urandom_range(1, 40);
                  gap_cnt <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
               end else begin
                  burst_cnt <= burst_cnt - 1;
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Receiver stall pattern: alternating ready runs and stall runs.
   int unsigned rx_run;
   bit          rx_phase;
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         rx_run <= 0;
         rx_phase <= 1'b0;
      end else if (hold_rx) begin
         rsp_ready <= 1'b0;
      end else if (rx_run == 0) begin
         rx_phase <= ~rx_phase;
         rsp_ready <= ~rx_phase;
         rx_run <= rx_phase ? $urandom_range(1, 12) : $urandom_range(0, 5);
      end else begin
         rx_run <= rx_run - 1;
      end
   end

   // Monitor: compare each taken digest word with the oldest prediction.
   always @(posedge clock) begin
      digest_beat_type exp_b;
      if (!reset && rsp_valid && rsp_ready) begin
         if (digest_queue.size() == 0) begin
            $error("digest word with nothing expected: %h", rsp_digest_word);
            errors++;
         end else begin
            exp_b = digest_queue.pop_front();
            if (rsp_digest_word !== exp_b.digest_word) begin
               $error("digest_word expected %h actual %h", exp_b.digest_word, rsp_digest_word);
               errors++;
            end
            if (rsp_word_index !== exp_b.word_index) begin
               $error("word_index expected %0d actual %0d", exp_b.word_index, rsp_word_index);
               errors++;
            end
            if (rsp_last_word !== exp_b.last_word) begin
               $error("last_word expected %0d actual %0d", exp_b.last_word, rsp_last_word);
               errors++;
            end
         end
      end
   end

   // Watchdog: count cycles in which neither channel moves a word.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IdleLimit) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      int len;
      hold_rx = 0;
      pause_tx = 0;
      reset = 1'b1;
      restart_hash();
      for (int i = 0; i < 64; i++) blk_q[i] = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty message, single bytes at the extremes, padding boundaries.
      add_message(0, 1'b1);
      pending_words.push_back('{8'h00, 1'b1, 1'b1});
      pending_words.push_back('{8'hff, 1'b1, 1'b0});
      pending_words.push_back('{8'h5a, 1'b0, 1'b0});
      pending_words.push_back('{8'ha5, 1'b0, 1'b1});
      add_message(55, 1'b0);
      add_message(63, 1'b1);
      add_message(64, 1'b0);
      wait (pending_words.size() == 0 && !req_valid);
      wait (digest_queue.size() == 0);
      repeat (250) @(posedge clock);

      // Hold the receiver off while the sender keeps offering words.
      hold_rx = 1;
      add_message(3, 1'b0);
      add_message(5, 1'b1);
      add_message(20, 1'b0);
      repeat (LongHold) @(posedge clock);
      hold_rx = 0;

      // Random short messages.
      len = 0;
      while (len < 20) begin
         int n;
         n = $urandom_range(0, 12);
         add_message(n, $urandom_range(0, 3) == 0);
         len += n + 1;
         if ($urandom_range(0, 2) == 0) begin
            // Pause the sender until every digest so far has come back.
            wait (pending_words.size() == 0 && !req_valid);
            pause_tx = 1;
            wait (digest_queue.size() == 0);
            pause_tx = 0;
         end
         wait (pending_words.size() < 40);
      end
      wait (pending_words.size() == 0 && !req_valid);
      wait (digest_queue.size() == 0);
      repeat (300) @(posedge clock);
      if (errors == 0 && digest_queue.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end
endmodule
